// ===== rtl/cmhp_pkg.sv =====
// Shared types, constants and result helpers for the message header parser.
package cmhp_pkg;

    localparam int MAX_ICV_DEF = 32;
    localparam int CFG_NUM     = 4;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_SEL_W   = 2;
    localparam int ICV_CFG_W   = 6;

    localparam logic [ICV_CFG_W-1:0] ICV_RST_SUITE0 = 6'd4;
    localparam logic [ICV_CFG_W-1:0] ICV_RST_SUITE1 = 6'd4;
    localparam logic [ICV_CFG_W-1:0] ICV_RST_SUITE2 = 6'd8;
    localparam logic [ICV_CFG_W-1:0] ICV_RST_SUITE3 = 6'd8;

    localparam logic [7:0] SUITE_LAST = 8'd3;

    localparam logic [2:0] HDR_IDX_FLAG  = 3'd0;
    localparam logic [2:0] HDR_IDX_VER   = 3'd1;
    localparam logic [2:0] HDR_IDX_SUITE = 3'd2;
    localparam logic [2:0] HDR_IDX_KEY   = 3'd3;
    localparam logic [2:0] SEQ_BYTES     = 3'd6;

    localparam logic ERR_SHORT = 1'b0;
    localparam logic ERR_SUITE = 1'b1;

    typedef enum logic [2:0] {
        KIND_KEY     = 3'd0,
        KIND_HEADER  = 3'd1,
        KIND_PAYLOAD = 3'd2,
        KIND_ICV     = 3'd3,
        KIND_ERROR   = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        PH_HDR,
        PH_KEY,
        PH_SEQ,
        PH_BODY,
        PH_DROP
    } phase_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_ERR,
        ST_FL_RD,
        ST_FL_PUSH
    } state_t;

    typedef enum logic [1:0] {
        TAIL_NONE,
        TAIL_ERR,
        TAIL_FLUSH
    } tail_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic push_err;
        logic flush_rd;
        logic flush_push;
    } cmd_t;

    typedef struct packed {
        logic  first_valid;
        tail_t tail;
        logic  flush_last;
    } status_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  data;
        logic        ext;
        logic [14:0] version;
        logic [7:0]  suite;
        logic [6:0]  key_len;
        logic [6:0]  short_key;
        logic [47:0] seq;
        logic        err;
        logic        done;
    } res_t;

    function automatic res_t res_byte(kind_t k, logic [7:0] b);
        res_t r;
        r      = '0;
        r.kind = k;
        r.data = b;
        return r;
    endfunction

    function automatic res_t res_error(logic code);
        res_t r;
        r      = '0;
        r.kind = KIND_ERROR;
        r.err  = code;
        r.done = 1'b1;
        return r;
    endfunction

endpackage

// ===== rtl/cmhp_ctrl.sv =====
// Sequencing state machine: accept, execute, error and ICV flush steps, output valid.
module cmhp_ctrl
    import cmhp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    output logic    out_valid,
    input  logic    out_stall,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   slot_free;
    logic   push;

    assign slot_free = !out_valid_reg || !out_stall;
    assign push      = (cmd.exec && status.first_valid) || cmd.push_err || cmd.flush_push;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (slot_free)
                begin
                    case (status.tail)
                        TAIL_ERR:   state_next = ST_ERR;
                        TAIL_FLUSH: state_next = ST_FL_RD;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_ERR:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_FL_RD:
            begin
                state_next = ST_FL_PUSH;
            end
            ST_FL_PUSH:
            begin
                if (slot_free)
                begin
                    state_next = status.flush_last ? ST_IDLE : ST_FL_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            ST_EXEC:    cmd.exec       = slot_free;
            ST_ERR:     cmd.push_err   = slot_free;
            ST_FL_RD:   cmd.flush_rd   = 1'b1;
            ST_FL_PUSH: cmd.flush_push = slot_free;
            default:    cmd            = '0;
        endcase
    end

    always_comb
    begin
        if (push)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == ST_EXEC))
        else $error("accepted transaction not followed by execute step");

    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !(out_valid_reg && out_stall))
        else $error("result loaded over a stalled result");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(push))
        else $error("output valid rose without a result load");

endmodule

// ===== rtl/cmhp_dp.sv =====
// Parse state, ICV configuration, ICV hold memory and result register.
module cmhp_dp
    import cmhp_pkg::*;
#(
    parameter int MAX_ICV = MAX_ICV_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cmd_t                 cmd,
    output status_t              status,
    input  logic [7:0]           data_byte,
    input  logic                 end_of_frame,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ICV_CFG_W-1:0] cfg_data,
    output res_t                 result
);

    localparam int CNT_W  = $clog2(MAX_ICV + 1);
    localparam int ADDR_W = (MAX_ICV > 1) ? $clog2(MAX_ICV) : 1;
    localparam int CMP_W  = (CNT_W > ICV_CFG_W) ? CNT_W : ICV_CFG_W;

    logic [ICV_CFG_W-1:0] icv_cfg_reg [CFG_NUM];

    phase_t             phase_reg;
    phase_t             phase_next;
    logic [2:0]         idx_reg;
    logic [2:0]         idx_next;
    logic [6:0]         key_cnt_reg;
    logic [6:0]         key_cnt_next;
    logic [CNT_W-1:0]   target_reg;
    logic [CNT_W-1:0]   target_next;
    logic [CNT_W-1:0]   fill_reg;
    logic [CNT_W-1:0]   fill_next;
    logic [ADDR_W-1:0]  head_reg;
    logic [ADDR_W-1:0]  head_next;
    logic [ADDR_W-1:0]  flush_ptr_reg;
    logic [ADDR_W-1:0]  flush_ptr_next;
    logic [CNT_W-1:0]   flush_left_reg;
    logic [CNT_W-1:0]   flush_left_next;

    logic               ext_reg;
    logic               ext_next;
    logic [14:0]        ver_reg;
    logic [14:0]        ver_next;
    logic [7:0]         suite_reg;
    logic [7:0]         suite_next;
    logic [6:0]         key_len_reg;
    logic [6:0]         key_len_next;
    logic [6:0]         short_reg;
    logic [6:0]         short_next;
    logic [47:0]        seq_reg;
    logic [47:0]        seq_next;
    logic               err_code_reg;
    logic               err_code_next;

    logic [7:0]         byte_reg;
    logic               eof_reg;
    logic [7:0]         rd_data_reg;
    logic [7:0]         hold_mem [MAX_ICV];
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    res_t               out_reg;
    res_t               first;
    res_t               icv_res;
    logic               first_valid;
    tail_t              tail;
    logic               restart;

    logic [ICV_CFG_W-1:0] cfg_sel;
    logic [CNT_W-1:0]     sat_target;
    logic [CNT_W-1:0]     head_inc;
    logic [ADDR_W-1:0]    head_wrap;
    logic [CNT_W-1:0]     fptr_inc;
    logic [ADDR_W-1:0]    fptr_wrap;

    assign cfg_sel    = icv_cfg_reg[byte_reg[CFG_SEL_W-1:0]];
    assign sat_target = (CMP_W'(cfg_sel) > CMP_W'(MAX_ICV)) ? CNT_W'(MAX_ICV) : CNT_W'(cfg_sel);

    assign head_inc  = CNT_W'(head_reg) + CNT_W'(1);
    assign head_wrap = (head_inc == target_reg) ? '0 : head_inc[ADDR_W-1:0];
    assign fptr_inc  = CNT_W'(flush_ptr_reg) + CNT_W'(1);
    assign fptr_wrap = (fptr_inc == target_reg) ? '0 : fptr_inc[ADDR_W-1:0];

    always_comb
    begin
        icv_res      = res_byte(KIND_ICV, rd_data_reg);
        icv_res.done = (flush_left_reg == CNT_W'(1));
    end

    always_comb
    begin
        phase_next      = phase_reg;
        idx_next        = idx_reg;
        key_cnt_next    = key_cnt_reg;
        target_next     = target_reg;
        fill_next       = fill_reg;
        head_next       = head_reg;
        flush_ptr_next  = flush_ptr_reg;
        flush_left_next = flush_left_reg;
        ext_next        = ext_reg;
        ver_next        = ver_reg;
        suite_next      = suite_reg;
        key_len_next    = key_len_reg;
        short_next      = short_reg;
        seq_next        = seq_reg;
        err_code_next   = err_code_reg;
        first           = '0;
        first_valid     = 1'b0;
        tail            = TAIL_NONE;
        restart         = 1'b0;
        mem_we          = 1'b0;
        mem_waddr       = head_reg;

        case (phase_reg)
            PH_HDR:
            begin
                case (idx_reg)
                    HDR_IDX_FLAG:
                    begin
                        ext_next = byte_reg[7];
                        ver_next = {byte_reg[6:0], 8'h00};
                    end
                    HDR_IDX_VER:
                    begin
                        ver_next = {ver_reg[14:8], byte_reg};
                    end
                    HDR_IDX_SUITE:
                    begin
                        suite_next = byte_reg;
                        if (byte_reg > SUITE_LAST)
                        begin
                            phase_next = PH_DROP;
                        end
                        else
                        begin
                            target_next = sat_target;
                        end
                    end
                    default:
                    begin
                        if (byte_reg[7])
                        begin
                            key_len_next = byte_reg[6:0];
                            short_next   = '0;
                            key_cnt_next = '0;
                            phase_next   = (byte_reg[6:0] != '0) ? PH_KEY : PH_SEQ;
                        end
                        else
                        begin
                            key_len_next = 7'd1;
                            short_next   = byte_reg[6:0];
                            phase_next   = PH_SEQ;
                        end
                        seq_next = '0;
                    end
                endcase
                idx_next = (idx_reg < HDR_IDX_KEY) ? idx_reg + 3'd1 : '0;
                if (eof_reg)
                begin
                    first_valid = 1'b1;
                    first       = res_error((phase_next == PH_DROP) ? ERR_SUITE : ERR_SHORT);
                    restart     = 1'b1;
                end
            end
            PH_KEY:
            begin
                first_valid  = 1'b1;
                first        = res_byte(KIND_KEY, byte_reg);
                key_cnt_next = key_cnt_reg + 7'd1;
                if (key_cnt_next == key_len_reg)
                begin
                    phase_next = PH_SEQ;
                    idx_next   = '0;
                end
                if (eof_reg)
                begin
                    tail          = TAIL_ERR;
                    err_code_next = ERR_SHORT;
                    restart       = 1'b1;
                end
            end
            PH_SEQ:
            begin
                seq_next = {seq_reg[39:0], byte_reg};
                idx_next = idx_reg + 3'd1;
                if (idx_next >= SEQ_BYTES)
                begin
                    first_valid     = 1'b1;
                    first.kind      = KIND_HEADER;
                    first.ext       = ext_reg;
                    first.version   = ver_reg;
                    first.suite     = suite_reg;
                    first.key_len   = key_len_reg;
                    first.short_key = short_reg;
                    first.seq       = seq_next;
                    phase_next      = PH_BODY;
                    fill_next       = '0;
                    head_next       = '0;
                    if (eof_reg)
                    begin
                        if (target_reg == '0)
                        begin
                            first.done = 1'b1;
                        end
                        else
                        begin
                            tail          = TAIL_ERR;
                            err_code_next = ERR_SHORT;
                        end
                        restart = 1'b1;
                    end
                end
                else if (eof_reg)
                begin
                    first_valid = 1'b1;
                    first       = res_error(ERR_SHORT);
                    restart     = 1'b1;
                end
            end
            PH_BODY:
            begin
                if (fill_reg < target_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = fill_reg[ADDR_W-1:0];
                    fill_next = fill_reg + CNT_W'(1);
                end
                else if (target_reg == '0)
                begin
                    first_valid = 1'b1;
                    first       = res_byte(KIND_PAYLOAD, byte_reg);
                end
                else
                begin
                    first_valid = 1'b1;
                    first       = res_byte(KIND_PAYLOAD, rd_data_reg);
                    mem_we      = 1'b1;
                    mem_waddr   = head_reg;
                    head_next   = head_wrap;
                end
                if (eof_reg)
                begin
                    if (fill_next == target_reg)
                    begin
                        if (target_reg == '0)
                        begin
                            first.done = 1'b1;
                        end
                        else
                        begin
                            tail            = TAIL_FLUSH;
                            flush_ptr_next  = head_next;
                            flush_left_next = target_reg;
                        end
                    end
                    else
                    begin
                        first_valid = 1'b1;
                        first       = res_error(ERR_SHORT);
                    end
                    restart = 1'b1;
                end
            end
            default:
            begin
                if (eof_reg)
                begin
                    first_valid = 1'b1;
                    first       = res_error(ERR_SUITE);
                    restart     = 1'b1;
                end
            end
        endcase

        if (restart)
        begin
            phase_next   = PH_HDR;
            idx_next     = '0;
            key_cnt_next = '0;
            fill_next    = '0;
            head_next    = '0;
            seq_next     = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HDR;
            idx_reg        <= '0;
            key_cnt_reg    <= '0;
            target_reg     <= '0;
            fill_reg       <= '0;
            head_reg       <= '0;
            flush_ptr_reg  <= '0;
            flush_left_reg <= '0;
            icv_cfg_reg[0] <= ICV_RST_SUITE0;
            icv_cfg_reg[1] <= ICV_RST_SUITE1;
            icv_cfg_reg[2] <= ICV_RST_SUITE2;
            icv_cfg_reg[3] <= ICV_RST_SUITE3;
        end
        else
        begin
            if (cfg_valid && (cfg_index < CFG_IDX_W'(CFG_NUM)))
            begin
                icv_cfg_reg[cfg_index[CFG_SEL_W-1:0]] <= cfg_data;
            end
            if (cmd.exec)
            begin
                phase_reg      <= phase_next;
                idx_reg        <= idx_next;
                key_cnt_reg    <= key_cnt_next;
                target_reg     <= target_next;
                fill_reg       <= fill_next;
                head_reg       <= head_next;
                flush_ptr_reg  <= flush_ptr_next;
                flush_left_reg <= flush_left_next;
            end
            if (cmd.flush_rd)
            begin
                flush_ptr_reg <= fptr_wrap;
            end
            if (cmd.flush_push)
            begin
                flush_left_reg <= flush_left_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            byte_reg    <= data_byte;
            eof_reg     <= end_of_frame;
            rd_data_reg <= hold_mem[head_reg];
        end
        else if (cmd.flush_rd)
        begin
            rd_data_reg <= hold_mem[flush_ptr_reg];
        end
        if (cmd.exec && mem_we)
        begin
            hold_mem[mem_waddr] <= byte_reg;
        end
        if (cmd.exec)
        begin
            ext_reg      <= ext_next;
            ver_reg      <= ver_next;
            suite_reg    <= suite_next;
            key_len_reg  <= key_len_next;
            short_reg    <= short_next;
            seq_reg      <= seq_next;
            err_code_reg <= err_code_next;
        end
        if (cmd.exec && first_valid)
        begin
            out_reg <= first;
        end
        else if (cmd.push_err)
        begin
            out_reg <= res_error(err_code_reg);
        end
        else if (cmd.flush_push)
        begin
            out_reg <= icv_res;
        end
    end

    assign status.first_valid = first_valid;
    assign status.tail        = tail;
    assign status.flush_last  = (flush_left_reg == CNT_W'(1));
    assign result             = out_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= target_reg)
        else $error("hold fill exceeds ICV length");

    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_BODY && target_reg != '0) |-> (CNT_W'(head_reg) < target_reg))
        else $error("hold head pointer outside ICV window");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.flush_push |-> (flush_left_reg != '0))
        else $error("ICV flush ran past its count");

endmodule

// ===== rtl/crisp_message_header_parser.sv =====
// Top level of the secure message header parser.
// Each accepted byte goes through the accept step, then an execute step that
// updates the parse state, writes the ICV hold memory and loads the result register;
// the next byte is taken once the control is back in its accept step. A byte that leaves
// an error behind a key id or header result adds an error step. The end of a frame that
// carries an ICV adds a read step and a result load step per ICV byte, as the hold
// memory's read port is registered. Output stall holds the execute, error and ICV load
// steps while a stalled result occupies the output.
// The hold memory needs no clearing after reset; only written entries are read.
module crisp_message_header_parser
    import cmhp_pkg::*;
#(
    parameter int MAX_ICV = MAX_ICV_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [7:0]           data_byte,
    input  logic                 end_of_frame,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [2:0]           kind,
    output logic [7:0]           out_byte,
    output logic                 ext_key_flag,
    output logic [14:0]          version,
    output logic [7:0]           suite_id,
    output logic [6:0]           key_id_len,
    output logic [6:0]           short_key_id,
    output logic [47:0]          seq_number,
    output logic                 error_code,
    output logic                 frame_done,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ICV_CFG_W-1:0] cfg_data
);

    cmd_t    cmd;
    status_t status;
    res_t    result;

    assign cfg_ready = 1'b1;

    cmhp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    cmhp_dp #(
        .MAX_ICV (MAX_ICV)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .data_byte    (data_byte),
        .end_of_frame (end_of_frame),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result       (result)
    );

    assign kind         = result.kind;
    assign out_byte     = result.data;
    assign ext_key_flag = result.ext;
    assign version      = result.version;
    assign suite_id     = result.suite;
    assign key_id_len   = result.key_len;
    assign short_key_id = result.short_key;
    assign seq_number   = result.seq;
    assign error_code   = result.err;
    assign frame_done   = result.done;

endmodule

// ===== test/crisp_message_header_parser_checker.sv =====
// Checker for the message header parser: predicts each result from accepted bytes and compares.
module crisp_message_header_parser_checker
    import cmhp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  logic [7:0]           data_byte,
    input  logic                 end_of_frame,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  logic [2:0]           kind,
    input  logic [7:0]           out_byte,
    input  logic                 ext_key_flag,
    input  logic [14:0]          version,
    input  logic [7:0]           suite_id,
    input  logic [6:0]           key_id_len,
    input  logic [6:0]           short_key_id,
    input  logic [47:0]          seq_number,
    input  logic                 error_code,
    input  logic                 frame_done,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ICV_CFG_W-1:0] cfg_data,
    output int                   mismatch_count,
    output int                   predicted_left
);

    localparam int MAX_ICV = MAX_ICV_DEF;

    logic [ICV_CFG_W-1:0] icv_len_cfg [CFG_NUM];
    phase_t               parse_phase;
    logic [7:0]           hdr_pos;
    logic                 ext_flag;
    logic [14:0]          ver_acc;
    logic [7:0]           suite_acc;
    logic [6:0]           key_len_acc;
    logic [6:0]           short_key_acc;
    logic [6:0]           key_seen;
    logic [47:0]          seq_acc;
    logic [5:0]           icv_want;
    logic [7:0]           held_bytes [$];
    res_t                 predicted_results [$];

    function automatic string describe(res_t r);
        return $sformatf({"kind %0d byte %02h ext %0b ver %04h suite %02h klen %0d skey %0d",
                          " seq %012h err %0b done %0b"},
                         r.kind, r.data, r.ext, r.version, r.suite, r.key_len, r.short_key,
                         r.seq, r.err, r.done);
    endfunction

    task automatic push_result(input kind_t k, input logic [7:0] b, input logic done);
        res_t r;
        r      = '0;
        r.kind = k;
        r.data = b;
        r.done = done;
        predicted_results.push_back(r);
    endtask

    task automatic push_error(input logic code);
        res_t r;
        r      = '0;
        r.kind = KIND_ERROR;
        r.err  = code;
        r.done = 1'b1;
        predicted_results.push_back(r);
    endtask

    task automatic restart_frame();
        parse_phase = PH_HDR;
        hdr_pos     = '0;
        key_seen    = '0;
        seq_acc     = '0;
        held_bytes.delete();
    endtask

    task automatic parse_byte(input logic [7:0] b, input logic eof);
        res_t r;
        int   n;
        case (parse_phase)
            PH_HDR:
            begin
                if (hdr_pos == HDR_IDX_FLAG)
                begin
                    ext_flag = b[7];
                    ver_acc  = {b[6:0], 8'h00};
                end
                else if (hdr_pos == HDR_IDX_VER)
                    ver_acc[7:0] = b;
                else if (hdr_pos == HDR_IDX_SUITE)
                begin
                    suite_acc = b;
                    if (b > SUITE_LAST)
                        parse_phase = PH_DROP;
                    else if (icv_len_cfg[b[1:0]] > MAX_ICV)
                        icv_want = 6'(MAX_ICV);
                    else
                        icv_want = icv_len_cfg[b[1:0]];
                end
                else
                begin
                    if (b[7])
                    begin
                        key_len_acc   = b[6:0];
                        short_key_acc = '0;
                        key_seen      = '0;
                        parse_phase   = (b[6:0] != 0) ? PH_KEY : PH_SEQ;
                    end
                    else
                    begin
                        key_len_acc   = 7'd1;
                        short_key_acc = b[6:0];
                        parse_phase   = PH_SEQ;
                    end
                    seq_acc = '0;
                end
                hdr_pos = (hdr_pos < HDR_IDX_KEY) ? hdr_pos + 8'd1 : 8'd0;
                if (eof)
                begin
                    push_error((parse_phase == PH_DROP) ? ERR_SUITE : ERR_SHORT);
                    restart_frame();
                end
            end
            PH_KEY:
            begin
                push_result(KIND_KEY, b, 1'b0);
                key_seen = key_seen + 7'd1;
                if (key_seen == key_len_acc)
                begin
                    parse_phase = PH_SEQ;
                    hdr_pos     = '0;
                end
                if (eof)
                begin
                    push_error(ERR_SHORT);
                    restart_frame();
                end
            end
            PH_SEQ:
            begin
                seq_acc = {seq_acc[39:0], b};
                hdr_pos = hdr_pos + 8'd1;
                if (hdr_pos >= SEQ_BYTES)
                begin
                    r           = '0;
                    r.kind      = KIND_HEADER;
                    r.ext       = ext_flag;
                    r.version   = ver_acc;
                    r.suite     = suite_acc;
                    r.key_len   = key_len_acc;
                    r.short_key = short_key_acc;
                    r.seq       = seq_acc;
                    r.done      = eof && (icv_want == 0);
                    predicted_results.push_back(r);
                    parse_phase = PH_BODY;
                    held_bytes.delete();
                    if (eof)
                    begin
                        if (icv_want != 0)
                            push_error(ERR_SHORT);
                        restart_frame();
                    end
                end
                else if (eof)
                begin
                    push_error(ERR_SHORT);
                    restart_frame();
                end
            end
            PH_BODY:
            begin
                if (held_bytes.size() < icv_want)
                    held_bytes.push_back(b);
                else if (icv_want == 0)
                    push_result(KIND_PAYLOAD, b, eof);
                else
                begin
                    push_result(KIND_PAYLOAD, held_bytes.pop_front(), 1'b0);
                    held_bytes.push_back(b);
                end
                if (eof)
                begin
                    if (held_bytes.size() == icv_want)
                    begin
                        n = held_bytes.size();
                        for (int i = 0; i < n; i++)
                            push_result(KIND_ICV, held_bytes[i], i == n - 1);
                    end
                    else
                        push_error(ERR_SHORT);
                    restart_frame();
                end
            end
            default:
            begin
                if (eof)
                begin
                    push_error(ERR_SUITE);
                    restart_frame();
                end
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        res_t actual;
        res_t wanted;
        if (!rst_n)
        begin
            icv_len_cfg[0] = ICV_RST_SUITE0;
            icv_len_cfg[1] = ICV_RST_SUITE1;
            icv_len_cfg[2] = ICV_RST_SUITE2;
            icv_len_cfg[3] = ICV_RST_SUITE3;
            ext_flag       = 1'b0;
            ver_acc        = '0;
            suite_acc      = '0;
            key_len_acc    = '0;
            short_key_acc  = '0;
            icv_want       = '0;
            restart_frame();
            predicted_results.delete();
            mismatch_count = 0;
            predicted_left = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready && cfg_index < CFG_NUM)
                icv_len_cfg[cfg_index[CFG_SEL_W-1:0]] = cfg_data;
            if (in_valid && !in_stall)
                parse_byte(data_byte, end_of_frame);
            if (out_valid && !out_stall)
            begin
                actual.kind      = kind_t'(kind);
                actual.data      = out_byte;
                actual.ext       = ext_key_flag;
                actual.version   = version;
                actual.suite     = suite_id;
                actual.key_len   = key_id_len;
                actual.short_key = short_key_id;
                actual.seq       = seq_number;
                actual.err       = error_code;
                actual.done      = frame_done;
                if (predicted_results.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result: %s", describe(actual));
                end
                else
                begin
                    wanted = predicted_results.pop_front();
                    if (actual !== wanted)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                        begin
                            $display("result mismatch at %0t", $realtime);
                            $display("  expected: %s", describe(wanted));
                            $display("  actual:   %s", describe(actual));
                        end
                    end
                end
            end
            predicted_left = predicted_results.size();
        end
    end

endmodule

// ===== test/tb_crisp_message_header_parser.sv =====
// Testbench top for the message header parser: clock, reset, byte and config stimulus, verdict.
module tb_crisp_message_header_parser;
    import cmhp_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_ICV_SUITE0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ICV_SUITE1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ICV_SUITE2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ICV_SUITE3 = 3'd3;
    localparam int                   CYCLE_LIMIT    = 10000000;
    localparam int                   IDLE_CYCLES    = 40;
    localparam int                   PHASE_ITEMS    = 100;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic [7:0]           data_byte;
    logic                 end_of_frame;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [2:0]           kind;
    logic [7:0]           out_byte;
    logic                 ext_key_flag;
    logic [14:0]          version;
    logic [7:0]           suite_id;
    logic [6:0]           key_id_len;
    logic [6:0]           short_key_id;
    logic [47:0]          seq_number;
    logic                 error_code;
    logic                 frame_done;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [ICV_CFG_W-1:0] cfg_data;
    int                   mismatch_count;
    int                   predicted_left;

    logic [ICV_CFG_W-1:0] icv_len_shadow [CFG_NUM];
    logic [7:0]           frame_buf [$];
    int                   items_sent = 0;
    int                   cycle_count = 0;
    int                   stall_left = 0;
    bit                   gaps_on = 1'b1;
    bit                   stalls_on = 1'b1;

    crisp_message_header_parser uut (.*);

    crisp_message_header_parser_checker checker_i (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic int pick_idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    always @(negedge clk)
    begin
        int n;
        if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left = stall_left - 1;
        end
        else
        begin
            n = stalls_on ? pick_idle_len() : 0;
            out_stall <= (n > 0);
            if (n > 0)
                stall_left = n - 1;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic eof);
        int gap;
        gap = gaps_on ? pick_idle_len() : 0;
        @(negedge clk);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid     <= 1'b1;
        data_byte    <= b;
        end_of_frame <= eof;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        items_sent++;
    endtask

    task automatic send_frame_buf();
        for (int i = 0; i < frame_buf.size(); i++)
            send_byte(frame_buf[i], i == frame_buf.size() - 1);
    endtask

    // drop valid, wait out all predicted results, then let the block go quiet
    task automatic settle_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (predicted_left != 0) @(negedge clk);
        repeat (IDLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_icv_len(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [ICV_CFG_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        if (idx < CFG_NUM)
            icv_len_shadow[idx[CFG_SEL_W-1:0]] = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_icv_lens(input logic [ICV_CFG_W-1:0] len0,
                                 input logic [ICV_CFG_W-1:0] len1,
                                 input logic [ICV_CFG_W-1:0] len2,
                                 input logic [ICV_CFG_W-1:0] len3);
        write_icv_len(REG_ICV_SUITE0, len0);
        write_icv_len(REG_ICV_SUITE1, len1);
        write_icv_len(REG_ICV_SUITE2, len2);
        write_icv_len(REG_ICV_SUITE3, len3);
        write_icv_len(CFG_IDX_W'($urandom_range(CFG_NUM, 7)), ICV_CFG_W'($urandom));
    endtask

    task automatic send_random_frame();
        int         pick;
        int         n;
        int         icv;
        logic [7:0] suite;
        pick      = $urandom_range(0, 99);
        gaps_on   = ($urandom_range(0, 3) != 0);
        stalls_on = ($urandom_range(0, 3) != 0);
        frame_buf.delete();
        frame_buf.push_back(8'($urandom));
        frame_buf.push_back(8'($urandom));
        if (pick < 10)
        begin
            frame_buf.push_back(8'($urandom_range(4, 255)));
            repeat ($urandom_range(0, 5)) frame_buf.push_back(8'($urandom));
        end
        else
        begin
            suite = 8'($urandom_range(0, 3));
            frame_buf.push_back(suite);
            if ($urandom_range(0, 99) < 55)
                frame_buf.push_back(8'($urandom_range(0, 127)));
            else
            begin
                n = ($urandom_range(0, 49) == 0) ? $urandom_range(8, 127) : $urandom_range(0, 5);
                frame_buf.push_back(8'h80 | 8'(n));
                repeat (n) frame_buf.push_back(8'($urandom));
            end
            repeat (SEQ_BYTES) frame_buf.push_back(8'($urandom));
            icv = icv_len_shadow[suite[1:0]];
            if (icv > MAX_ICV_DEF)
                icv = MAX_ICV_DEF;
            repeat (icv + $urandom_range(0, 8)) frame_buf.push_back(8'($urandom));
            if (pick < 28)
            begin
                n = $urandom_range(1, frame_buf.size() - 1);
                while (frame_buf.size() > n) frame_buf.pop_back();
            end
        end
        send_frame_buf();
    endtask

    initial
    begin
        int phase_end;
        in_valid          = 1'b0;
        data_byte         = '0;
        end_of_frame      = 1'b0;
        cfg_valid         = 1'b0;
        cfg_index         = '0;
        cfg_data          = '0;
        icv_len_shadow[0] = ICV_RST_SUITE0;
        icv_len_shadow[1] = ICV_RST_SUITE1;
        icv_len_shadow[2] = ICV_RST_SUITE2;
        icv_len_shadow[3] = ICV_RST_SUITE3;
        rst_n             = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        load_icv_lens(6'd0, 6'd63, 6'd4, 6'd1);
        frame_buf = '{8'h00};
        send_frame_buf();
        frame_buf = '{8'hFF, 8'hFF, 8'h04};
        send_frame_buf();
        frame_buf = '{8'h7F, 8'h00, 8'h00, 8'h80,
                      8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
        send_frame_buf();
        frame_buf = '{8'h80, 8'hFF, 8'h03, 8'h7F,
                      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hA5, 8'h5A};
        send_frame_buf();

        for (int p = 0; p < 5; p++)
        begin
            settle_idle();
            case (p)
                0: load_icv_lens(ICV_RST_SUITE0, ICV_RST_SUITE1, ICV_RST_SUITE2, ICV_RST_SUITE3);
                1: load_icv_lens(6'd32, 6'd0, 6'd33, 6'd2);
                2: load_icv_lens(6'd1, 6'd3, 6'd0, 6'd63);
                3: load_icv_lens(6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                                 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
                default: load_icv_lens(6'($urandom_range(0, 8)), 6'($urandom_range(0, 8)),
                                       6'($urandom_range(0, 8)), 6'($urandom_range(0, 8)));
            endcase
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end) send_random_frame();
        end

        settle_idle();
        if (mismatch_count == 0 && predicted_left == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
